@@ rtl/ucs_pkg.sv @@
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types and constants of the URI component scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package ucs_pkg;

  // parse phase codes
  localparam logic [3:0] PH_START  = 4'd0;
  localparam logic [3:0] PH_SCHEME = 4'd1;
  localparam logic [3:0] PH_AUTH   = 4'd2;
  localparam logic [3:0] PH_AUTHSL = 4'd3;
  localparam logic [3:0] PH_HOST   = 4'd4;
  localparam logic [3:0] PH_PORT   = 4'd5;
  localparam logic [3:0] PH_IPV6   = 4'd6;
  localparam logic [3:0] PH_ACCEPT = 4'd7;
  localparam logic [3:0] PH_REJECT = 4'd8;

  // delimiter characters
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;

  // allowed-character table, bit n set when byte value n is allowed
  localparam logic [255:0] ALLOW_TAB = {
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h47ff_fffe, 32'haf_ff_ff_ff, 32'haf_ff_ff_fa, 32'h0000_0000
  };

  typedef struct packed {
    logic [3:0] phase;
    logic       scheme;
    logic       userpass;
    logic       host;
    logic       port;
  } scan_state_t;

  localparam scan_state_t SCAN_RESET = '{
    phase: PH_START, scheme: 1'b0, userpass: 1'b0, host: 1'b0, port: 1'b0
  };

  typedef struct packed {
    logic valid_res;
    logic scheme_seen;
    logic userpass_seen;
    logic host_seen;
    logic port_seen;
  } scan_res_t;

endpackage

`default_nettype wire

@@ rtl/ucs_if.sv @@
// ----------------------------------------------------------------------------
// ucs_if
// Valid/ready channels of the URI component scanner: byte in, result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_last;

  modport source (output valid, output char_byte, output is_last, input ready);
  modport sink   (input valid, input char_byte, input is_last, output ready);
endinterface

interface ucs_res_if;
  logic valid;
  logic ready;
  logic valid_res;
  logic scheme_seen;
  logic userpass_seen;
  logic host_seen;
  logic port_seen;

  modport source (output valid, output valid_res, output scheme_seen,
                  output userpass_seen, output host_seen, output port_seen,
                  input ready);
  modport sink   (input valid, input valid_res, input scheme_seen,
                  input userpass_seen, input host_seen, input port_seen,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/uri_component_scanner.sv @@
// ----------------------------------------------------------------------------
// uri_component_scanner
// Streaming URI syntax check with scheme/userpass/host/port presence flags.
// ----------------------------------------------------------------------------
// usage:
//   in_i carries one URI byte per request (char_byte) with is_last marking
//   the final byte of a string. res_o gives one result request per string,
//   on its last byte: valid_res plus the four presence flags (all zero when
//   the string is rejected).
//   each accepted byte lands in an input register; the phase machine then
//   updates from it and, for a last byte, loads the result register.
//   with the result register free, res_o.valid rises once the last byte has
//   passed the input register into the result register. the phase update is
//   combinational. throughput: one byte per cycle; a stalled result blocks
//   only a following last byte; other bytes keep flowing, since they
//   produce no result. when that last byte waits in the input register,
//   in_i.ready drops until res_o is taken.
//   reset clears both registers' valid bits and puts the phase machine in
//   its start state with all flags clear.
// ----------------------------------------------------------------------------
`default_nettype none

module uri_component_scanner
  import ucs_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  ucs_in_if.sink      in_i,
  ucs_res_if.source   res_o
);

  // input register
  logic        in_vld_q;
  logic [7:0]  in_char_q;
  logic        in_last_q;

  // phase machine state
  scan_state_t state_q, state_d;

  // result register
  logic        res_vld_q;
  scan_res_t   res_q, res_d;

  logic        proc;      // input register consumed this cycle
  logic        in_fire;

  // a last byte may only proceed when the result slot is free or draining
  assign proc    = in_vld_q && (!in_last_q || !res_vld_q || res_o.ready);
  assign in_i.ready = !in_vld_q || proc;
  assign in_fire = in_i.valid && in_i.ready;

  ucs_step u_step (
    .state_i (state_q),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_char_q <= in_i.char_byte;
      in_last_q <= in_i.is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SCAN_RESET;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (proc && in_last_q) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && in_last_q) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.valid_res     = res_q.valid_res;
  assign res_o.scheme_seen   = res_q.scheme_seen;
  assign res_o.userpass_seen = res_q.userpass_seen;
  assign res_o.host_seen     = res_q.host_seen;
  assign res_o.port_seen     = res_q.port_seen;

  // phase code stays within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase <= PH_REJECT)
    else $error("phase code out of range");

  // a rejected string reports no flags
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_q.valid_res |->
      !res_q.scheme_seen && !res_q.userpass_seen && !res_q.host_seen &&
      !res_q.port_seen)
    else $error("flags set on rejected string");

  // a scheme is only recorded after a host was started
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.scheme_seen |-> res_q.host_seen)
    else $error("scheme without host");

  // end of string returns the machine to its start state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_last_q |=> state_q == SCAN_RESET)
    else $error("state not cleared after last byte");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && !res_o.ready |-> !(proc && in_last_q))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

@@ rtl/ucs_step.sv @@
// ----------------------------------------------------------------------------
// ucs_step
// One-byte update of the URI phase machine and its presence flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ucs_step
  import ucs_pkg::*;
(
  input  scan_state_t state_i,
  input  logic [7:0]  char_i,
  input  logic        last_i,
  output scan_state_t state_o,
  output scan_res_t   res_o
);

  scan_state_t nx;
  logic        char_ok;
  logic        is_term;

  assign char_ok = ALLOW_TAB[char_i];
  assign is_term = (char_i == CH_SLASH) || (char_i == CH_QUEST) || (char_i == CH_HASH);

  always_comb begin
    nx = state_i;
    if ((state_i.phase == PH_ACCEPT) || (state_i.phase == PH_REJECT)) begin
      nx = state_i;
    end else if (state_i.phase == PH_AUTHSL) begin
      // byte after ":/" bypasses the table
      if (char_i == CH_SLASH) begin
        nx.scheme = 1'b1;
        nx.phase  = PH_HOST;
      end else begin
        nx.port  = 1'b1;
        nx.phase = PH_ACCEPT;
      end
    end else if (!char_ok) begin
      nx.phase = PH_REJECT;
    end else begin
      case (state_i.phase)
        PH_START, PH_SCHEME: begin
          if ((state_i.phase == PH_START) && (char_i == CH_SLASH)) begin
            nx.phase = PH_ACCEPT;
          end else if ((state_i.phase == PH_START) && (char_i == CH_LBRK)) begin
            nx.phase = PH_IPV6;
            nx.host  = 1'b1;
          end else begin
            if (state_i.phase == PH_START) begin
              nx.phase = PH_SCHEME;
              nx.host  = 1'b1;
            end
            if (char_i == CH_COLON) begin
              nx.phase = PH_AUTH;
            end else if (char_i == CH_AT) begin
              nx.phase    = PH_HOST;
              nx.userpass = 1'b1;
            end else if (is_term) begin
              nx.phase = PH_ACCEPT;
            end
          end
        end
        PH_AUTH: begin
          if (char_i == CH_SLASH) begin
            nx.phase = PH_AUTHSL;
          end else begin
            nx.port  = 1'b1;
            nx.phase = PH_PORT;
          end
        end
        PH_HOST: begin
          if (char_i == CH_AT) begin
            nx.userpass = 1'b1;
          end else if (char_i == CH_LBRK) begin
            nx.phase = PH_IPV6;
          end else if (char_i == CH_COLON) begin
            nx.port  = 1'b1;
            nx.phase = PH_PORT;
          end else if (is_term) begin
            nx.phase = PH_ACCEPT;
          end
        end
        PH_PORT: begin
          if (char_i == CH_AT) begin
            nx.port     = 1'b0;
            nx.userpass = 1'b1;
            nx.phase    = PH_HOST;
          end else if ((char_i == CH_LBRK) || (char_i == CH_RBRK) ||
                       (char_i == CH_COLON)) begin
            nx.phase = PH_REJECT;
          end else if (is_term) begin
            nx.port  = 1'b1;
            nx.phase = PH_ACCEPT;
          end
        end
        PH_IPV6: begin
          if (char_i == CH_RBRK) begin
            nx.phase = PH_HOST;
          end else if ((char_i == CH_AT) || (char_i == CH_LBRK) || is_term) begin
            nx.phase = PH_REJECT;
          end
        end
        default: begin
          nx.phase = PH_REJECT;
        end
      endcase
    end
  end

  always_comb begin
    res_o = '0;
    if (nx.phase != PH_REJECT) begin
      res_o.valid_res     = 1'b1;
      res_o.scheme_seen   = nx.scheme;
      res_o.userpass_seen = nx.userpass;
      res_o.host_seen     = nx.host;
      // string ending right after ":/" counts as a port
      res_o.port_seen     = nx.port || (nx.phase == PH_AUTHSL);
    end
  end

  // the last byte returns the machine to its start state
  assign state_o = last_i ? SCAN_RESET : nx;

endmodule

`default_nettype wire
